// ----- hdl/assert_macros.svh -----
// assertion macros shared by the render block
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/rpcr_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, register codes and types of the raw pixel color render block
// no dependencies
package rpcr_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int COEF_W    = 16;
	localparam int NUM_LANES = 3;
	localparam int ROW_W     = NUM_LANES * COEF_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = ROW_W;

	localparam int TABLE_ADDR_BITS_DEF = 16;
	localparam int COEFF_FRAC_BITS_DEF = 12;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WB_RED_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WB_BLUE_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_RED      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_GREEN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BLUE     = 3'd4;

	// item kinds
	localparam logic FUNC_RENDER = 1'b0;
	localparam logic FUNC_WRITE  = 1'b1;

	// control that travels down the pipeline with each word
	typedef struct packed {
		logic                valid;
		logic                func;
		logic [SAMPLE_W-1:0] entry_index;
		logic [SAMPLE_W-1:0] entry_value;
	} ctl_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
	} rgb_t;

endpackage

// ----- hdl/rpcr_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for input words and result words
// depends on rpcr_pkg
interface rpcr_in_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [rpcr_pkg::SAMPLE_W-1:0] in_red;
	logic [rpcr_pkg::SAMPLE_W-1:0] in_green;
	logic [rpcr_pkg::SAMPLE_W-1:0] in_blue;
	logic [rpcr_pkg::SAMPLE_W-1:0] entry_index;
	logic [rpcr_pkg::SAMPLE_W-1:0] entry_value;

	modport source (output valid, func, in_red, in_green, in_blue, entry_index, entry_value,
		input ready);
	modport sink (input valid, func, in_red, in_green, in_blue, entry_index, entry_value,
		output ready);
endinterface

interface rpcr_out_if;
	logic                          valid;
	logic                          ready;
	logic [rpcr_pkg::SAMPLE_W-1:0] out_red;
	logic [rpcr_pkg::SAMPLE_W-1:0] out_green;
	logic [rpcr_pkg::SAMPLE_W-1:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ----- hdl/rpcr_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module rpcr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/rpcr_bal.sv -----
`timescale 1ns / 1ps
// white balance front end: gain products, then saturation to Q16.F
// depends on rpcr_pkg
module rpcr_bal #(
	parameter int COEFF_FRAC_BITS = rpcr_pkg::COEFF_FRAC_BITS_DEF,
	localparam int CH_W = rpcr_pkg::SAMPLE_W + COEFF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  rpcr_pkg::ctl_t                ctl_in,
	input  logic [rpcr_pkg::SAMPLE_W-1:0] in_red,
	input  logic [rpcr_pkg::SAMPLE_W-1:0] in_green,
	input  logic [rpcr_pkg::SAMPLE_W-1:0] in_blue,
	input  logic [rpcr_pkg::GAIN_W-1:0]   red_gain,
	input  logic [rpcr_pkg::GAIN_W-1:0]   blue_gain,
	output rpcr_pkg::ctl_t                ctl_s2,
	output logic [CH_W-1:0]               ch_s2 [rpcr_pkg::NUM_LANES]
);

	localparam int PROD_W = rpcr_pkg::SAMPLE_W + rpcr_pkg::GAIN_W;
	localparam logic [CH_W-1:0] CH_TOP = {{rpcr_pkg::SAMPLE_W{1'b1}}, {COEFF_FRAC_BITS{1'b0}}};
	localparam logic [PROD_W-1:0] PROD_TOP = PROD_W'(CH_TOP);

	rpcr_pkg::ctl_t              ctl_s1;
	logic [PROD_W-1:0]           red_s1;
	logic [PROD_W-1:0]           blue_s1;
	logic [rpcr_pkg::SAMPLE_W-1:0] green_s1;

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	// stage 1: gain products, green passes at unity
	always_ff @(posedge clk) begin
		if (adv) begin
			red_s1   <= PROD_W'(in_red) * PROD_W'(red_gain);
			blue_s1  <= PROD_W'(in_blue) * PROD_W'(blue_gain);
			green_s1 <= in_green;
		end
	end

	// stage 2: saturate at full scale
	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s2[0] <= (red_s1 > PROD_TOP) ? CH_TOP : red_s1[CH_W-1:0];
			ch_s2[1] <= {green_s1, {COEFF_FRAC_BITS{1'b0}}};
			ch_s2[2] <= (blue_s1 > PROD_TOP) ? CH_TOP : blue_s1[CH_W-1:0];
		end
	end

endmodule

// ----- hdl/rpcr_lane.sv -----
`timescale 1ns / 1ps
// one output channel: matrix row dot product, clamp, tone table lookup
// depends on rpcr_pkg and rpcr_ram
module rpcr_lane #(
	parameter int COEFF_FRAC_BITS = rpcr_pkg::COEFF_FRAC_BITS_DEF,
	parameter int TABLE_ADDR_BITS = rpcr_pkg::TABLE_ADDR_BITS_DEF,
	localparam int CH_W = rpcr_pkg::SAMPLE_W + COEFF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [CH_W-1:0]               ch_s2 [rpcr_pkg::NUM_LANES],
	input  logic [rpcr_pkg::ROW_W-1:0]    row,
	input  rpcr_pkg::ctl_t                ctl_s4,
	output logic [rpcr_pkg::SAMPLE_W-1:0] level_s5
);

	localparam int PW = CH_W + rpcr_pkg::COEF_W;
	localparam int SW = PW + 2;
	localparam int WHOLE_W = SW - 2 * COEFF_FRAC_BITS;
	localparam int SW_HI = rpcr_pkg::SAMPLE_W;

	logic signed [CH_W:0]                  chs [rpcr_pkg::NUM_LANES];
	logic signed [rpcr_pkg::COEF_W-1:0]    cf  [rpcr_pkg::NUM_LANES];
	logic signed [PW-1:0]                  prod_s3 [rpcr_pkg::NUM_LANES];
	logic signed [SW-1:0]                  sum;
	logic [WHOLE_W-1:0]                    whole;
	logic [rpcr_pkg::SAMPLE_W-1:0]         level;
	logic [TABLE_ADDR_BITS-1:0]            addr_s4;

	// signed operands of the row products
	for (genvar k = 0; k < rpcr_pkg::NUM_LANES; k++) begin : g_opnd
		assign chs[k] = {1'b0, ch_s2[k]};
		assign cf[k]  = row[k*rpcr_pkg::COEF_W +: rpcr_pkg::COEF_W];
	end

	// stage 3: three products of the row
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < rpcr_pkg::NUM_LANES; k++) begin
				prod_s3[k] <= chs[k] * cf[k];
			end
		end
	end

	// sum, truncate toward zero, clamp to the sample range
	assign sum   = SW'(prod_s3[0]) + SW'(prod_s3[1]) + SW'(prod_s3[2]);
	assign whole = sum[SW-1:2*COEFF_FRAC_BITS];

	always_comb begin
		if (sum[SW-1]) begin
			level = '0;
		end else if (|whole[WHOLE_W-1:SW_HI]) begin
			level = '1;
		end else begin
			level = whole[rpcr_pkg::SAMPLE_W-1:0];
		end
	end

	// stage 4: table address from the top bits of the level
	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s4 <= level[rpcr_pkg::SAMPLE_W-1 -: TABLE_ADDR_BITS];
		end
	end

	// tone table copy of this lane, written by table write words in order
	rpcr_ram #(
		.WIDTH (rpcr_pkg::SAMPLE_W),
		.DEPTH (1 << TABLE_ADDR_BITS)
	) u_table (
		.clk   (clk),
		.we    (adv && ctl_s4.valid && (ctl_s4.func == rpcr_pkg::FUNC_WRITE)),
		.waddr (ctl_s4.entry_index[TABLE_ADDR_BITS-1:0]),
		.wdata (ctl_s4.entry_value),
		.re    (adv),
		.raddr (addr_s4),
		.rdata (level_s5)
	);

endmodule

// ----- hdl/rpcr_out.sv -----
`timescale 1ns / 1ps
// output and skid registers for the result word merged from the three lane results
// depends on rpcr_pkg, rpcr_if and assert_macros.svh
`include "assert_macros.svh"

module rpcr_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  rpcr_pkg::rgb_t data,
	output logic          adv,
	rpcr_out_if.source    result
);

	logic           out_valid_q;
	logic           skid_valid_q;
	rpcr_pkg::rgb_t out_q;
	rpcr_pkg::rgb_t skid_q;

	// pipeline moves while the skid register is free
	assign adv = !skid_valid_q;

	// occupancy of output and skid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (result.ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= take;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	// word data
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (result.ready) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || result.ready) begin
			if (take) begin
				out_q <= data;
			end
		end else if (take) begin
			skid_q <= data;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_red   = out_q.red;
	assign result.out_green = out_q.green;
	assign result.out_blue  = out_q.blue;

	`ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_q || out_valid_q, "skid full with output empty")
	`ASSERT_NEXT(a_skid_drains, skid_valid_q && result.ready, !skid_valid_q && out_valid_q, "skid did not drain")
	`ASSERT_NEXT(a_skid_catches, take && out_valid_q && !result.ready && !skid_valid_q, skid_valid_q, "word lost on stall")

endmodule

// ----- hdl/raw_pixel_color_render_top.sv -----
`timescale 1ns / 1ps
// top of the raw pixel color render block: config registers, pipeline control, lanes
// depends on rpcr_pkg, rpcr_if, rpcr_bal, rpcr_lane, rpcr_out
//
//  channel  | dir | handshake    | word
//  ---------+-----+--------------+---------------------------------------------------
//  item     | in  | valid/ready  | func, in_red, in_green, in_blue, entry_index/value
//  result   | out | valid/ready  | out_red, out_green, out_blue
//  cfg      | in  | cfg_we       | cfg_index, cfg_data
//
// one word per clock unless stalled; a render word passes stages 1 to 5 and the output
// register to show on result, a table write word gives no result and lands in the table
// reset clears control and loads unity gains and the identity matrix; table is undefined
// the five-stage pipeline stalls as a whole only when both output and skid registers hold
// words; item.ready falls then and rises once result takes the skid word
module raw_pixel_color_render_top #(
	parameter int TABLE_ADDR_BITS = rpcr_pkg::TABLE_ADDR_BITS_DEF,
	parameter int COEFF_FRAC_BITS = rpcr_pkg::COEFF_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rpcr_in_if.sink                         item,
	rpcr_out_if.source                      result,
	input  logic                            cfg_we,
	input  logic [rpcr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpcr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CH_W = rpcr_pkg::SAMPLE_W + COEFF_FRAC_BITS;
	localparam logic [rpcr_pkg::COEF_W-1:0] ONE_Q = rpcr_pkg::COEF_W'(1 << COEFF_FRAC_BITS);
	localparam logic [rpcr_pkg::COEF_W-1:0] ZERO_C = '0;

	logic [rpcr_pkg::GAIN_W-1:0]   red_gain_q;
	logic [rpcr_pkg::GAIN_W-1:0]   blue_gain_q;
	logic [rpcr_pkg::ROW_W-1:0]    row_q [rpcr_pkg::NUM_LANES];

	logic                          adv;
	rpcr_pkg::ctl_t                ctl_in;
	rpcr_pkg::ctl_t                ctl_s2;
	rpcr_pkg::ctl_t                ctl_s3;
	rpcr_pkg::ctl_t                ctl_s4;
	rpcr_pkg::ctl_t                ctl_s5;
	logic [CH_W-1:0]               ch_s2 [rpcr_pkg::NUM_LANES];
	logic [rpcr_pkg::SAMPLE_W-1:0] level_s5 [rpcr_pkg::NUM_LANES];
	rpcr_pkg::rgb_t                merged;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_gain_q  <= ONE_Q;
			blue_gain_q <= ONE_Q;
			row_q[0]    <= {ZERO_C, ZERO_C, ONE_Q};
			row_q[1]    <= {ZERO_C, ONE_Q, ZERO_C};
			row_q[2]    <= {ONE_Q, ZERO_C, ZERO_C};
		end else if (cfg_we) begin
			unique case (cfg_index)
				rpcr_pkg::REG_WB_RED_GAIN:  red_gain_q  <= cfg_data[rpcr_pkg::GAIN_W-1:0];
				rpcr_pkg::REG_WB_BLUE_GAIN: blue_gain_q <= cfg_data[rpcr_pkg::GAIN_W-1:0];
				rpcr_pkg::REG_ROW_RED:      row_q[0]    <= cfg_data;
				rpcr_pkg::REG_ROW_GREEN:    row_q[1]    <= cfg_data;
				rpcr_pkg::REG_ROW_BLUE:     row_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input word control
	assign item.ready         = adv;
	assign ctl_in.valid       = item.valid;
	assign ctl_in.func        = item.func;
	assign ctl_in.entry_index = item.entry_index;
	assign ctl_in.entry_value = item.entry_value;

	// white balance, stages 1 and 2
	rpcr_bal #(
		.COEFF_FRAC_BITS (COEFF_FRAC_BITS)
	) u_bal (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_in    (ctl_in),
		.in_red    (item.in_red),
		.in_green  (item.in_green),
		.in_blue   (item.in_blue),
		.red_gain  (red_gain_q),
		.blue_gain (blue_gain_q),
		.ctl_s2    (ctl_s2),
		.ch_s2     (ch_s2)
	);

	// control for stages 3 to 5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// one lane per output channel
	for (genvar j = 0; j < rpcr_pkg::NUM_LANES; j++) begin : g_lane
		rpcr_lane #(
			.COEFF_FRAC_BITS (COEFF_FRAC_BITS),
			.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
		) u_lane (
			.clk      (clk),
			.adv      (adv),
			.ch_s2    (ch_s2),
			.row      (row_q[j]),
			.ctl_s4   (ctl_s4),
			.level_s5 (level_s5[j])
		);
	end

	assign merged.red   = level_s5[0];
	assign merged.green = level_s5[1];
	assign merged.blue  = level_s5[2];

	// result merge and output buffering
	rpcr_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (ctl_s5.valid && (ctl_s5.func == rpcr_pkg::FUNC_RENDER)),
		.data   (merged),
		.adv    (adv),
		.result (result)
	);

endmodule

// ----- tb/raw_pixel_color_render_top_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for raw_pixel_color_render_top: white balance, color matrix, tone table
// depends on rpcr_pkg, rpcr_if and the block under test; predicts each result word itself
module raw_pixel_color_render_top_tb;

	localparam int SAMPLE_W = rpcr_pkg::SAMPLE_W;
	localparam int GAIN_W = rpcr_pkg::GAIN_W;
	localparam int COEF_W = rpcr_pkg::COEF_W;
	localparam int ROW_W = rpcr_pkg::ROW_W;
	localparam int NUM_LANES = rpcr_pkg::NUM_LANES;
	localparam int CFG_IDX_W = rpcr_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = rpcr_pkg::CFG_DATA_W;
	localparam int TAB = rpcr_pkg::TABLE_ADDR_BITS_DEF;
	localparam int FRAC = rpcr_pkg::COEFF_FRAC_BITS_DEF;
	localparam int TBL = 1 << TAB;
	localparam int SETTLE = 10;
	localparam int RANDOM_WORDS = 650;
	localparam int RANDOM_PHASES = 8;
	localparam int RUN_LIMIT_NS = 10_000_000;
	localparam logic [GAIN_W-1:0] ONE_Q = GAIN_W'(1 << FRAC);
	localparam longint SAT_Q = longint'(65535) << FRAC;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = rpcr_pkg::REG_ROW_BLUE + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rpcr_in_if  item ();
	rpcr_out_if result ();

	raw_pixel_color_render_top #(
		.TABLE_ADDR_BITS(TAB),
		.COEFF_FRAC_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state: registers, tone table and pending pixels
	logic [GAIN_W-1:0] gain_red;
	logic [GAIN_W-1:0] gain_blue;
	logic [ROW_W-1:0]  mtx_row [NUM_LANES];
	logic [SAMPLE_W-1:0] tone_mem [TBL];
	bit                tone_set [TBL];
	rpcr_pkg::rgb_t    pixel_q [$];
	int                errors = 0;
	int                words_sent = 0;
	bit                in_gappy = 1'b0;
	bit                out_gappy = 1'b0;
	int                stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("raw_pixel_color_render_top: mismatch");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// white balance in Q16.F, saturating
	function automatic longint wb_scale(logic [SAMPLE_W-1:0] sample, logic [GAIN_W-1:0] gain);
		longint p;
		p = longint'(sample) * longint'(gain);
		if (p > SAT_Q)
			p = SAT_Q;
		return p;
	endfunction

	function automatic longint coef(logic [ROW_W-1:0] row, int k);
		logic signed [COEF_W-1:0] c;
		c = row[COEF_W*k +: COEF_W];
		return longint'(c);
	endfunction

	// matrix row sum, truncated and clamped, to a table index
	function automatic logic [SAMPLE_W-1:0] lane_index(logic [ROW_W-1:0] row,
			longint cr, longint cg, longint cb);
		longint acc;
		acc = cr * coef(row, 0) + cg * coef(row, 1) + cb * coef(row, 2);
		if (acc <= 0)
			return '0;
		acc = acc >>> (2 * FRAC);
		if (acc > 65535)
			acc = 65535;
		return SAMPLE_W'(acc) >> (SAMPLE_W - TAB);
	endfunction

	function automatic rpcr_pkg::rgb_t tone_index(logic [SAMPLE_W-1:0] r,
			logic [SAMPLE_W-1:0] g, logic [SAMPLE_W-1:0] b);
		longint cr, cg, cb;
		rpcr_pkg::rgb_t ix;
		cr = wb_scale(r, gain_red);
		cg = wb_scale(g, ONE_Q);
		cb = wb_scale(b, gain_blue);
		ix.red = lane_index(mtx_row[0], cr, cg, cb);
		ix.green = lane_index(mtx_row[1], cr, cg, cb);
		ix.blue = lane_index(mtx_row[2], cr, cg, cb);
		return ix;
	endfunction

	// half 8-bit tones, half 16-bit tones
	function automatic logic [SAMPLE_W-1:0] tone_value();
		if ($urandom_range(0, 1))
			return SAMPLE_W'($urandom_range(0, 255));
		return SAMPLE_W'($urandom);
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 5)
			return SAMPLE_W'($urandom_range(0, 4095));
		return SAMPLE_W'($urandom);
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 4)
			return GAIN_W'($urandom);
		return GAIN_W'($urandom_range(2048, 16384));
	endfunction

	function automatic logic [ROW_W-1:0] pack_row(logic [COEF_W-1:0] cr, logic [COEF_W-1:0] cg,
			logic [COEF_W-1:0] cb);
		return {cb, cg, cr};
	endfunction

	// random rows: raw bits, extremes, or a plausible color correction row
	function automatic logic [ROW_W-1:0] rand_row(int lane);
		int r;
		logic [COEF_W-1:0] c [NUM_LANES];
		r = $urandom_range(0, 5);
		if (r == 0)
			return ROW_W'({$urandom, $urandom});
		if (r == 1)
			return $urandom_range(0, 1) ? pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF)
				: pack_row(16'h8000, 16'h8000, 16'h8000);
		for (int k = 0; k < NUM_LANES; k++)
			c[k] = (k == lane) ? COEF_W'($urandom_range(3000, 7000))
				: COEF_W'(int'($urandom_range(0, 3000)) - 1500);
		return pack_row(c[0], c[1], c[2]);
	endfunction

	// register write while the block is idle
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			rpcr_pkg::REG_WB_RED_GAIN: gain_red = data[GAIN_W-1:0];
			rpcr_pkg::REG_WB_BLUE_GAIN: gain_blue = data[GAIN_W-1:0];
			rpcr_pkg::REG_ROW_RED: mtx_row[0] = data[ROW_W-1:0];
			rpcr_pkg::REG_ROW_GREEN: mtx_row[1] = data[ROW_W-1:0];
			rpcr_pkg::REG_ROW_BLUE: mtx_row[2] = data[ROW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_cfg();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// send one input word and account for it once taken
	task automatic send_word(input logic func, input logic [SAMPLE_W-1:0] r,
			input logic [SAMPLE_W-1:0] g, input logic [SAMPLE_W-1:0] b,
			input logic [SAMPLE_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
		int gap;
		rpcr_pkg::rgb_t ix;
		rpcr_pkg::rgb_t want;
		gap = in_gappy ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			item.valid <= 1'b0;
		end
		@(negedge clk);
		item.valid <= 1'b1;
		item.func <= func;
		item.in_red <= r;
		item.in_green <= g;
		item.in_blue <= b;
		item.entry_index <= idx;
		item.entry_value <= val;
		do @(posedge clk); while (!item.ready);
		words_sent++;
		if (func == rpcr_pkg::FUNC_WRITE) begin
			tone_mem[idx[TAB-1:0]] = val;
			tone_set[idx[TAB-1:0]] = 1'b1;
		end else begin
			ix = tone_index(r, g, b);
			want.red = tone_mem[ix.red];
			want.green = tone_mem[ix.green];
			want.blue = tone_mem[ix.blue];
			pixel_q.push_back(want);
		end
	endtask

	task automatic fill_entry(input logic [SAMPLE_W-1:0] e);
		if (!tone_set[e])
			send_word(rpcr_pkg::FUNC_WRITE, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
				SAMPLE_W'($urandom), e, tone_value());
	endtask

	// a render word, preceded by writes of any table entry it would read unwritten
	task automatic render_pixel(input logic [SAMPLE_W-1:0] r, input logic [SAMPLE_W-1:0] g,
			input logic [SAMPLE_W-1:0] b);
		rpcr_pkg::rgb_t ix;
		ix = tone_index(r, g, b);
		fill_entry(ix.red);
		fill_entry(ix.green);
		fill_entry(ix.blue);
		send_word(rpcr_pkg::FUNC_RENDER, r, g, b, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
	endtask

	// idle the input, wait out pending pixels and trailing table writes
	task automatic drain();
		@(negedge clk);
		item.valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// result side back-pressure
	always @(negedge clk) begin
		if (!out_gappy || !arst_n) begin
			result.ready <= 1'b1;
		end else if (stall_left > 0) begin
			result.ready <= 1'b0;
			stall_left--;
		end else begin
			result.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// compare each result word with the oldest pending pixel
	always @(posedge clk) begin : check_result
		rpcr_pkg::rgb_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pixel_q.size() == 0) begin
				$error("result word with no pending pixel");
				errors++;
			end else begin
				want = pixel_q.pop_front();
				if (result.out_red !== want.red) begin
					$error("out_red: expected %h, got %h", want.red, result.out_red);
					errors++;
				end
				if (result.out_green !== want.green) begin
					$error("out_green: expected %h, got %h", want.green, result.out_green);
					errors++;
				end
				if (result.out_blue !== want.blue) begin
					$error("out_blue: expected %h, got %h", want.blue, result.out_blue);
					errors++;
				end
			end
		end
	end

	// reset config: unity gains, identity matrix
	task automatic test_identity();
		render_pixel(16'h0000, 16'h0000, 16'h0000);
		render_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		render_pixel(16'h0001, 16'h8000, 16'h7FFF);
		render_pixel(16'hAAAA, 16'h5555, 16'h00FF);
		drain();
	endtask

	// gain extremes: saturation of the balanced value and zero gain
	task automatic test_gain_limits();
		set_reg(rpcr_pkg::REG_WB_RED_GAIN, CFG_DATA_W'(16'hFFFF));
		set_reg(rpcr_pkg::REG_WB_BLUE_GAIN, '0);
		end_cfg();
		render_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		render_pixel(16'h0010, 16'h012C, 16'hFFFF);
		render_pixel(16'h0001, 16'h0001, 16'h0001);
		drain();
		set_reg(rpcr_pkg::REG_WB_RED_GAIN, '0);
		set_reg(rpcr_pkg::REG_WB_BLUE_GAIN, CFG_DATA_W'(16'hFFFF));
		end_cfg();
		render_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
		render_pixel(16'h1234, 16'h0800, 16'h4000);
		drain();
	endtask

	// coefficient extremes, negative sums clamping to zero, a typical correction matrix
	task automatic test_matrix_limits();
		set_reg(rpcr_pkg::REG_WB_RED_GAIN, CFG_DATA_W'(ONE_Q));
		set_reg(rpcr_pkg::REG_WB_BLUE_GAIN, CFG_DATA_W'(ONE_Q));
		set_reg(rpcr_pkg::REG_ROW_RED, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
		set_reg(rpcr_pkg::REG_ROW_GREEN, pack_row(16'h8000, 16'h8000, 16'h8000));
		set_reg(rpcr_pkg::REG_ROW_BLUE, pack_row(16'h7FFF, 16'h8000, 16'h0000));
		end_cfg();
		render_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		render_pixel(16'h0000, 16'h0000, 16'h0000);
		render_pixel(16'h0001, 16'h0002, 16'h0003);
		drain();
		set_reg(rpcr_pkg::REG_ROW_RED, pack_row(16'h1C00, -16'sh0800, -16'sh0400));
		set_reg(rpcr_pkg::REG_ROW_GREEN, pack_row(-16'sh0300, 16'h1600, -16'sh0300));
		set_reg(rpcr_pkg::REG_ROW_BLUE, pack_row(-16'sh0200, -16'sh0600, 16'h1800));
		end_cfg();
		render_pixel(16'd40000, 16'd0, 16'd0);
		render_pixel(16'd0, 16'd40000, 16'd0);
		render_pixel(16'd0, 16'd0, 16'd40000);
		render_pixel(16'd20000, 16'd20000, 16'd20000);
		drain();
	endtask

	// writes to indexes past the last register must leave the config alone
	task automatic test_unused_index();
		for (int i = int'(REG_UNUSED_LO); i <= int'(REG_UNUSED_HI); i++)
			set_reg(CFG_IDX_W'(i), CFG_DATA_W'({$urandom, $urandom}));
		end_cfg();
		render_pixel(16'd40000, 16'd1000, 16'd3000);
		render_pixel(16'hFFFF, 16'h0000, 16'h8000);
		drain();
	endtask

	// random phases: new settings each time, mostly renders with random table writes mixed in
	task automatic test_random();
		int stop;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0) begin
				set_reg(rpcr_pkg::REG_WB_RED_GAIN, CFG_DATA_W'(ONE_Q));
				set_reg(rpcr_pkg::REG_WB_BLUE_GAIN, CFG_DATA_W'(ONE_Q));
				set_reg(rpcr_pkg::REG_ROW_RED, pack_row(ONE_Q, '0, '0));
				set_reg(rpcr_pkg::REG_ROW_GREEN, pack_row('0, ONE_Q, '0));
				set_reg(rpcr_pkg::REG_ROW_BLUE, pack_row('0, '0, ONE_Q));
			end else begin
				set_reg(rpcr_pkg::REG_WB_RED_GAIN, CFG_DATA_W'(rand_gain()));
				set_reg(rpcr_pkg::REG_WB_BLUE_GAIN, CFG_DATA_W'(rand_gain()));
				set_reg(rpcr_pkg::REG_ROW_RED, rand_row(0));
				set_reg(rpcr_pkg::REG_ROW_GREEN, rand_row(1));
				set_reg(rpcr_pkg::REG_ROW_BLUE, rand_row(2));
				if ($urandom_range(0, 2) == 0)
					set_reg(CFG_IDX_W'($urandom_range(int'(REG_UNUSED_LO), int'(REG_UNUSED_HI))),
						CFG_DATA_W'({$urandom, $urandom}));
			end
			end_cfg();
			in_gappy = ph[0];
			out_gappy = ph[1];
			stop = words_sent + RANDOM_WORDS / RANDOM_PHASES;
			while (words_sent < stop) begin
				if ($urandom_range(0, 99) < 12)
					send_word(rpcr_pkg::FUNC_WRITE, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
						SAMPLE_W'($urandom), SAMPLE_W'($urandom), tone_value());
				else
					render_pixel(rand_sample(), rand_sample(), rand_sample());
			end
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item.valid = 1'b0;
		item.func = rpcr_pkg::FUNC_RENDER;
		item.in_red = '0;
		item.in_green = '0;
		item.in_blue = '0;
		item.entry_index = '0;
		item.entry_value = '0;
		result.ready = 1'b0;
		gain_red = ONE_Q;
		gain_blue = ONE_Q;
		mtx_row[0] = pack_row(ONE_Q, '0, '0);
		mtx_row[1] = pack_row('0, ONE_Q, '0);
		mtx_row[2] = pack_row('0, '0, ONE_Q);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		in_gappy = 1'b1;
		out_gappy = 1'b1;
		test_identity();
		test_gain_limits();
		test_matrix_limits();
		test_unused_index();
		test_random();
		drain();

		if (errors == 0)
			$display("raw_pixel_color_render_top: match");
		else
			$display("raw_pixel_color_render_top: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rpcr_pkg.sv
hdl/rpcr_if.sv
hdl/rpcr_ram.sv
hdl/rpcr_bal.sv
hdl/rpcr_lane.sv
hdl/rpcr_out.sv
hdl/raw_pixel_color_render_top.sv
tb/raw_pixel_color_render_top_tb.sv
